// ----- hdl/ncl_pkg.sv -----
// Package for the neighbour cache: item types, stored row, sequencer states.
// No dependencies; every other file imports it.
package ncl_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SLOT_W  = 4;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] addr_upper;
        logic [ADDR_W-1:0] addr_lower;
        logic [MAC_W-1:0]  entry_mac;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac_out;
        logic [SLOT_W-1:0] slot;
        logic              solicit_needed;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  key_upper;
        logic [ADDR_W-1:0]  key_lower;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } row_t;

    typedef struct packed {
        logic match;   // valid entry, key equal
        logic free;    // entry not valid
    } scan_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ----- hdl/ncl_mem.sv -----
// Entry store: one row per slot (keys, link address, stamp), registered read.
// Depends on ncl_pkg.
module ncl_mem #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IDX_W   = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  ncl_pkg::row_t    wdata,
    input  logic [IDX_W-1:0] raddr,
    output ncl_pkg::row_t    rdata
);
    import ncl_pkg::*;

    row_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ncl_scan.sv -----
// Shared compare unit: key equality and stamp ordering for one entry a cycle,
// tracking the oldest entry seen so far. Depends on ncl_pkg.
module ncl_scan #(
    parameter int unsigned IDX_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     first,
    input  logic [IDX_W-1:0]         idx,
    input  logic                     entry_valid,
    input  ncl_pkg::row_t            row,
    input  logic [ncl_pkg::ADDR_W-1:0] key_upper,
    input  logic [ncl_pkg::ADDR_W-1:0] key_lower,
    output ncl_pkg::scan_flags_t     flags,
    output logic [IDX_W-1:0]         victim
);
    import ncl_pkg::*;

    logic [STAMP_W-1:0] best_stamp_reg;
    logic [STAMP_W-1:0] best_stamp_next;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               older;

    assign flags.match = entry_valid && (row.key_upper == key_upper)
                         && (row.key_lower == key_lower);
    assign flags.free  = !entry_valid;

    // strict less-than: the earliest slot keeps a tie
    assign older = first || (row.stamp < best_stamp_reg);

    always_comb
    begin
        victim          = older ? idx : best_idx_reg;
        best_stamp_next = older ? row.stamp : best_stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_stamp_reg <= '0;
            best_idx_reg   <= '0;
        end
        else if (en)
        begin
            best_stamp_reg <= best_stamp_next;
            best_idx_reg   <= victim;
        end
    end

endmodule

// ----- hdl/neighbor_cache_lru.sv -----
// Neighbour cache top level: sequencer, valid bits, access counter, result register.
// Depends on ncl_pkg, ncl_mem, ncl_scan.
//
// An item is taken when start is high and busy is low; busy then stays high
// until its result is shown. The entry memory is read one slot per cycle and
// each slot goes through the one compare unit; a lookup stops at the first
// matching slot and an insert at the first free one, while a miss or an insert
// over a full cache reads every slot. The next item can be taken in the same
// cycle as the result is shown. The result is on rsp when done is high for
// exactly one cycle; done cannot be held off.
module neighbor_cache_lru #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ncl_pkg::req_t req,
    output logic          done,
    output ncl_pkg::rsp_t rsp
);
    import ncl_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = IDX_W + 1;

    state_t             state_reg, state_next;
    req_t               req_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic               hit_reg;
    logic               miss_reg;
    row_t               hrow_reg;
    logic [STAMP_W-1:0] counter_reg;
    logic [ENTRIES-1:0] valid_reg;
    rsp_t               rsp_reg;
    logic               done_reg;

    logic               accept;
    logic               issue;
    logic               stop_hit;
    logic               stop_free;
    logic               last;
    logic               scan_end;
    logic               is_lookup;
    logic [STAMP_W-1:0] stamp_new;

    logic               mem_we;
    row_t               mem_wdata;
    row_t               mem_rdata;
    scan_flags_t        flags;
    logic [IDX_W-1:0]   victim;

    ncl_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tgt_reg),
        .wdata (mem_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    ncl_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (cmp_vld_reg),
        .first       (cmp_idx_reg == '0),
        .idx         (cmp_idx_reg),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .row         (mem_rdata),
        .key_upper   (req_reg.addr_upper),
        .key_lower   (req_reg.addr_lower),
        .flags       (flags),
        .victim      (victim)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign is_lookup = (req_reg.command == CMD_LOOKUP);
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(ENTRIES));
    assign stop_hit  = cmp_vld_reg && is_lookup && flags.match;
    assign stop_free = cmp_vld_reg && !is_lookup && flags.free;
    assign last      = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign scan_end  = (state_reg == ST_SCAN) && (stop_hit || stop_free || last);
    assign stamp_new = counter_reg + STAMP_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SCAN;
            ST_SCAN:  if (scan_end) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_wdata = hrow_reg;
        case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_SCAN:  busy = 1'b1;
            ST_WRITE:
            begin
                mem_we = !miss_reg;
                if (hit_reg)
                begin
                    mem_wdata       = hrow_reg;
                    mem_wdata.stamp = stamp_new;
                end
                else
                begin
                    mem_wdata.key_upper = req_reg.addr_upper;
                    mem_wdata.key_lower = req_reg.addr_lower;
                    mem_wdata.mac       = req_reg.entry_mac;
                    mem_wdata.stamp     = stamp_new;
                end
            end
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            counter_reg <= '0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            miss_reg    <= 1'b0;
            tgt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WRITE);
            if (accept)
            begin
                rd_cnt_reg  <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= issue && !scan_end;
                if (issue)
                begin
                    rd_cnt_reg  <= rd_cnt_reg + CNT_W'(1);
                    cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
                end
            end
            if (scan_end)
            begin
                hit_reg  <= stop_hit;
                miss_reg <= is_lookup && !stop_hit;
                tgt_reg  <= (stop_hit || stop_free) ? cmp_idx_reg : victim;
            end
            if ((state_reg == ST_WRITE) && !miss_reg)
            begin
                counter_reg <= stamp_new;
                valid_reg[tgt_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (scan_end)
        begin
            hrow_reg <= mem_rdata;
        end
        if (state_reg == ST_WRITE)
        begin
            rsp_reg.hit            <= hit_reg;
            rsp_reg.mac_out        <= hit_reg ? hrow_reg.mac : '0;
            rsp_reg.slot           <= miss_reg ? '0 : SLOT_W'(tgt_reg);
            rsp_reg.solicit_needed <= miss_reg;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- hdl/ncl_chk.sv -----
// Port-level checker for the neighbour cache, bound to the top level.
// Depends on ncl_pkg and neighbor_cache_lru.
module ncl_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ncl_pkg::rsp_t rsp
);
    import ncl_pkg::*;

    // done never strobes two in a row
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but busy not raised");

    a_release_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_hit_excl_solicit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.hit && rsp.solicit_needed))
        else $error("hit and solicit both set");

    a_miss_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.mac_out == '0))
        else $error("link address not zero without a hit");

endmodule

bind neighbor_cache_lru ncl_chk u_ncl_chk (.*);

// ----- test/neighbor_cache_lru_test.sv -----
// Testbench for neighbor_cache_lru: directed and random lookups and inserts,
// each result checked against a behavioural model of the LRU cache held here.
// Depends on ncl_pkg and the neighbor_cache_lru RTL.
module neighbor_cache_lru_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ncl_pkg::*;

    localparam int unsigned CACHE_SLOTS = 16;
    localparam int unsigned SETTLE_CYCLES = CACHE_SLOTS + 9;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned POOL_SIZE = 24;
    localparam int unsigned RANDOM_ITEMS = 400;

    typedef struct {
        req_t        req;
        int unsigned gap;      // idle cycles before this item is offered
        bit          drain;    // hold the item until every result is back
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    pending_t req_backlog[$];
    rsp_t awaited_rsp[$];
    int unsigned gap_left = 0;
    int unsigned fail_count = 0;
    int unsigned stall_cycles = 0;

    // model state
    logic [ADDR_W-1:0]  key_hi [CACHE_SLOTS];
    logic [ADDR_W-1:0]  key_lo [CACHE_SLOTS];
    logic [MAC_W-1:0]   link_addr [CACHE_SLOTS];
    logic [STAMP_W-1:0] stamps [CACHE_SLOTS] = '{default: '0};
    bit                 line_valid [CACHE_SLOTS] = '{default: 1'b0};
    logic [STAMP_W-1:0] use_counter = '0;

    logic [ADDR_W-1:0] pool_hi [POOL_SIZE];
    logic [ADDR_W-1:0] pool_lo [POOL_SIZE];

    neighbor_cache_lru #(
        .ENTRIES(CACHE_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp)
    );

    always #6 clk = ~clk;

    // Applies one item to the model cache and returns the result it causes.
    function automatic rsp_t cache_access(input req_t r);
        rsp_t o;
        bit found;
        int unsigned victim;
        logic [STAMP_W-1:0] oldest;
        o = '0;
        found = 1'b0;
        if (r.command == CMD_LOOKUP) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (!found && line_valid[i] && key_hi[i] == r.addr_upper
                    && key_lo[i] == r.addr_lower) begin
                    found = 1'b1;
                    use_counter = use_counter + 1'b1;
                    stamps[i] = use_counter;
                    o.hit = 1'b1;
                    o.mac_out = link_addr[i];
                    o.slot = SLOT_W'(i);
                end
            end
            o.solicit_needed = !found;
        end
        else begin
            victim = 0;
            oldest = stamps[0];
            // first free slot wins, else the lowest stamp, earliest on ties
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (!found) begin
                    if (!line_valid[i]) begin
                        victim = i;
                        found = 1'b1;
                    end
                    else if (stamps[i] < oldest) begin
                        oldest = stamps[i];
                        victim = i;
                    end
                end
            end
            key_hi[victim] = r.addr_upper;
            key_lo[victim] = r.addr_lower;
            link_addr[victim] = r.entry_mac;
            use_counter = use_counter + 1'b1;
            stamps[victim] = use_counter;
            line_valid[victim] = 1'b1;
            o.slot = SLOT_W'(victim);
        end
        return o;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic cmd, input logic [ADDR_W-1:0] up,
                            input logic [ADDR_W-1:0] lo, input logic [MAC_W-1:0] mac,
                            input int unsigned gap, input bit drain);
        pending_t p;
        p.req.command = cmd;
        p.req.addr_upper = up;
        p.req.addr_lower = lo;
        p.req.entry_mac = mac;
        p.gap = gap;
        p.drain = drain;
        req_backlog.push_back(p);
    endtask

    // driver: offers items from the backlog, predicts each on acceptance
    always @(posedge clk or negedge rst_n) begin : driver
        logic next_start;
        req_t next_req;
        int unsigned gl;
        pending_t head;
        if (!rst_n) begin
            start <= 1'b0;
            req <= '0;
            gap_left <= 0;
        end
        else begin
            next_start = start;
            next_req = req;
            gl = gap_left;
            if (start && !busy) begin
                awaited_rsp.push_back(cache_access(req));
                next_start = 1'b0;
                gl = (req_backlog.size() != 0) ? req_backlog[0].gap : 0;
            end
            if (!next_start && req_backlog.size() != 0) begin
                if (gl != 0)
                    gl = gl - 1;
                else if (!req_backlog[0].drain || awaited_rsp.size() == 0) begin
                    head = req_backlog.pop_front();
                    next_req = head.req;
                    next_start = 1'b1;
                    if (req_backlog.size() != 0)
                        gl = 0;
                end
            end
            start <= next_start;
            req <= next_req;
            gap_left <= gl;
        end
    end

    always @(posedge clk) begin : monitor
        rsp_t want;
        if (rst_n && done) begin
            if (awaited_rsp.size() == 0) begin
                $error("unexpected result: hit %0d slot %0d", rsp.hit, rsp.slot);
                fail_count <= fail_count + 1;
            end
            else begin
                want = awaited_rsp.pop_front();
                if (rsp.hit !== want.hit)
                    $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                if (rsp.mac_out !== want.mac_out)
                    $error("mac_out: expected %h, got %h", want.mac_out, rsp.mac_out);
                if (rsp.slot !== want.slot)
                    $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                if (rsp.solicit_needed !== want.solicit_needed)
                    $error("solicit_needed: expected %0d, got %0d",
                           want.solicit_needed, rsp.solicit_needed);
                if (rsp !== want)
                    fail_count <= fail_count + 1;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("neighbor_cache_lru_test: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] ones;
        logic [ADDR_W-1:0] up;
        logic [ADDR_W-1:0] lo;
        logic cmd;
        int unsigned k;
        int unsigned gap;
        ones = '1;

        // directed: empty cache, extremes, partial key matches, duplicates
        add_item(CMD_LOOKUP, ones, ones, 48'h123456789abc, 0, 1'b0);
        add_item(CMD_INSERT, '0, '0, '0, 0, 1'b0);
        add_item(CMD_INSERT, ones, ones, '1, 0, 1'b0);
        add_item(CMD_LOOKUP, '0, '0, '1, 0, 1'b0);
        add_item(CMD_LOOKUP, ones, ones, '0, 0, 1'b0);
        add_item(CMD_LOOKUP, ones, '0, '0, 0, 1'b0);
        add_item(CMD_LOOKUP, '0, 64'd1, '0, 0, 1'b0);
        add_item(CMD_INSERT, '0, '0, 48'ha5a5a5a5a5a5, 0, 1'b0);
        add_item(CMD_LOOKUP, '0, '0, '0, 0, 1'b0);
        // fill the remaining slots, then force an eviction of the least recent
        for (int i = 0; i < 13; i++)
            add_item(CMD_INSERT, rand_word(), rand_word(), MAC_W'(rand_word()), 0, 1'b0);
        add_item(CMD_INSERT, rand_word(), rand_word(), 48'h5a5a5a5a5a5a, 0, 1'b0);
        add_item(CMD_LOOKUP, ones, ones, '0, 0, 1'b1);
        add_item(CMD_LOOKUP, '0, '0, '0, 0, 1'b0);

        // key pool larger than the cache; some keys share one half with another
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = (i % 4 == 1) ? pool_hi[i-1] : rand_word();
            pool_lo[i] = (i % 4 == 2) ? pool_lo[i-1] : rand_word();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            cmd = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
            if ($urandom_range(0, 9) == 0) begin
                up = rand_word();
                lo = rand_word();
            end
            else begin
                k = $urandom_range(0, POOL_SIZE - 1);
                up = pool_hi[k];
                lo = pool_lo[k];
            end
            gap = ((n / 60) % 3 == 1) ? 0 : pick_gap();
            add_item(cmd, up, lo, MAC_W'(rand_word()), gap,
                     n == 0 || n == 100 || n == 250);
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (req_backlog.size() != 0 || start || awaited_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && awaited_rsp.size() == 0)
            $display("neighbor_cache_lru_test: clean");
        else
            $display("neighbor_cache_lru_test: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ncl_pkg.sv
hdl/ncl_mem.sv
hdl/ncl_scan.sv
hdl/neighbor_cache_lru.sv
hdl/ncl_chk.sv
test/neighbor_cache_lru_test.sv
